// ----- src/sparse_row_variance_max_defines.svh -----
// Assertion helpers shared by the checker files of this block.
// Each helper samples on the rising edge of clk and is held off while rst_n is low.
`ifndef SPARSE_ROW_VARIANCE_MAX_DEFINES_SVH
`define SPARSE_ROW_VARIANCE_MAX_DEFINES_SVH

// A property that must hold at every sampled edge.
`define SRVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SRVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/srvm_pkg.sv -----
package srvm_pkg;

    // Fixed formats of the result words.
    localparam int FRACTION_BITS  = 16;
    localparam int VAR_BITS       = 48;
    localparam int SQ_BITS        = 64;
    localparam int OUT_TDATA_BITS = 2 * VAR_BITS;

    // The bit-serial divider takes one quotient bit per cycle.
    localparam int DIV_STEPS      = SQ_BITS;
    localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS);

    // Input side-band layout.
    localparam int IN_TUSER_BITS    = 2;
    localparam int TUSER_HAS_ENTRY  = 0;
    localparam int TUSER_MATRIX_END = 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic square;
        logic subtract;
        logic result_load;
    } srvm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } srvm_status_t;

endpackage

// ----- src/sparse_row_variance_max.sv -----
// Sparse row variance with running maximum.
// Input stream s_axis: one stored matrix entry per request. tdata carries the signed
// Q16.16 entry, tuser bit 0 says whether the entry is present (clear for an empty row),
// tuser bit 1 marks the end of the matrix and tlast the end of a row.
// Output stream m_axis: one result per closed row, carrying the row variance and the
// largest variance so far, both unsigned Q32.16; tlast marks the row closing the matrix.
// The cfg channel writes the column count N; it is always ready and should be written
// only while no row is in progress.
// Entries are taken one per cycle while no row close is in progress. A request that closes
// a row holds off the next entry while the accumulate pipeline drains, the dividers load,
// the bit-serial dividers run (one quotient bit per cycle), and then the mean square, the
// subtraction and the result load follow.
// A result waits in the output register while entries of the next row keep flowing in;
// only the next row close waits for that register to be taken.
// Reset clears the sums, the running maximum and the output valid, and sets N to one.
module sparse_row_variance_max
    import srvm_pkg::*;
#(
    parameter int VALUE_BITS  = 32,
    parameter int COLUMN_BITS = 24
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_value
    input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // has_entry, matrix_end
    input  logic [IN_TUSER_BITS-1:0]             s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // row_variance, max_variance
    output logic [OUT_TDATA_BITS-1:0]            m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [COLUMN_BITS:0]                 cfg_data
);

    srvm_cmd_t           cmd;
    srvm_status_t        status;
    logic [VAR_BITS-1:0] row_variance;
    logic [VAR_BITS-1:0] max_variance;

    assign cfg_ready = 1'b1;

    srvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_close (s_axis_tlast || s_axis_tuser[TUSER_MATRIX_END]),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srvm_datapath #(
        .VALUE_BITS  (VALUE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_entry         ($signed(s_axis_tdata[VALUE_BITS-1:0])),
        .in_has           (s_axis_tuser[TUSER_HAS_ENTRY]),
        .in_final         (s_axis_tuser[TUSER_MATRIX_END]),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_row_variance (row_variance),
        .out_max_variance (max_variance),
        .out_final        (m_axis_tlast)
    );

    assign m_axis_tdata = {max_variance, row_variance};

endmodule

// ----- src/srvm_divider.sv -----
module srvm_divider
    import srvm_pkg::*;
#(
    parameter int DIVISOR_BITS = 25
)
(
    input  logic                    clk,
    input  logic                    load,
    input  logic                    step,
    input  logic [SQ_BITS-1:0]      dividend,
    input  logic [DIVISOR_BITS-1:0] divisor,
    output logic [SQ_BITS-1:0]      quotient
);

    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [DIVISOR_BITS-1:0] rem_next;
    logic [SQ_BITS-1:0]      work_reg;
    logic [SQ_BITS-1:0]      work_next;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;
    logic                    fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb
    begin
        trial     = {rem_reg, work_reg[SQ_BITS-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        work_next = {work_reg[SQ_BITS-2:0], fits};
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= '0;
            work_reg <= dividend;
        end
        else if (step)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign quotient = work_reg;

endmodule

// ----- src/srvm_ctrl.sv -----
module srvm_ctrl
    import srvm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_close,
    output logic         in_ready,
    input  srvm_status_t status,
    output srvm_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_ACCUM    = 6'b000001,
        ST_DRAIN    = 6'b000010,
        ST_DIVIDE   = 6'b000100,
        ST_SQUARE   = 6'b001000,
        ST_SUBTRACT = 6'b010000,
        ST_RESULT   = 6'b100000
    } srvm_state_t;

    srvm_state_t               state_reg;
    srvm_state_t               state_next;
    logic [DIV_COUNT_BITS-1:0] count_reg;
    logic [DIV_COUNT_BITS-1:0] count_next;

    // Sequencing of a row close: drain, divide, square, subtract, deliver.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_close)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.div_load = 1'b1;
                    count_next   = DIV_COUNT_BITS'(DIV_STEPS - 1);
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_SUBTRACT;
            end
            ST_SUBTRACT:
            begin
                cmd.subtract = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/srvm_datapath.sv -----
module srvm_datapath
    import srvm_pkg::*;
#(
    parameter int VALUE_BITS  = 32,
    parameter int COLUMN_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srvm_cmd_t                    cmd,
    output srvm_status_t                 status,
    input  logic signed [VALUE_BITS-1:0] in_entry,
    input  logic                         in_has,
    input  logic                         in_final,
    input  logic                         cfg_write,
    input  logic [COLUMN_BITS:0]         cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [VAR_BITS-1:0]          out_row_variance,
    output logic [VAR_BITS-1:0]          out_max_variance,
    output logic                         out_final
);

    localparam int SUM_BITS     = VALUE_BITS + COLUMN_BITS;
    localparam int DIVISOR_BITS = COLUMN_BITS + 1;
    localparam logic [VALUE_BITS-1:0]   MEAN_CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [DIVISOR_BITS-1:0] COL_TOP  = {1'b1, {COLUMN_BITS{1'b0}}};
    localparam logic [DIVISOR_BITS-1:0] COL_ONE  = DIVISOR_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic [DIVISOR_BITS-1:0]       columns_reg;
    logic [VALUE_BITS-1:0]         mag_reg;
    logic signed [VALUE_BITS-1:0]  value_reg;
    logic                          p1_valid_reg;
    logic                          p2_valid_reg;
    logic [SQ_BITS-1:0]            sq_reg;
    logic signed [SUM_BITS-1:0]    row_sum_reg;
    logic signed [SUM_BITS-1:0]    row_sum_next;
    logic [SQ_BITS-1:0]            square_sum_reg;
    logic [SQ_BITS-1:0]            square_sum_next;
    logic                          final_reg;
    logic [SQ_BITS-1:0]            msq_reg;
    logic [SQ_BITS-1:0]            var_reg;
    logic [VAR_BITS-1:0]           best_reg;
    logic                          out_valid_reg;
    logic [VAR_BITS-1:0]           out_row_reg;
    logic [VAR_BITS-1:0]           out_max_reg;
    logic                          out_final_reg;

    logic [VALUE_BITS-1:0]         in_raw;
    logic [VALUE_BITS-1:0]         in_mag;
    logic [2*VALUE_BITS-1:0]       sq_prod;
    logic signed [SUM_BITS:0]      sum_wide;
    logic [SQ_BITS:0]              sqsum_wide;
    logic [SUM_BITS-1:0]           sum_raw;
    logic [SUM_BITS-1:0]           sum_mag;
    logic [SQ_BITS-1:0]            q_mean;
    logic [SQ_BITS-1:0]            q_square;
    logic [VALUE_BITS-1:0]         mean_c;
    logic [2*VALUE_BITS-1:0]       msq_prod;
    logic [SQ_BITS-1:0]            var_next;
    logic [VAR_BITS-1:0]           row_var;
    logic [VAR_BITS-1:0]           new_max;
    logic [DIVISOR_BITS-1:0]       columns_next;

    // Magnitude of the incoming entry; the most negative value maps to 2^(VALUE_BITS-1).
    assign in_raw = $unsigned(in_entry);
    assign in_mag = in_entry[VALUE_BITS-1] ? (~in_raw + 1'b1) : in_raw;

    // Stage one: exact square and saturating signed sum.
    assign sq_prod  = mag_reg * mag_reg;
    assign sum_wide = $signed({row_sum_reg[SUM_BITS-1], row_sum_reg})
                    + (SUM_BITS+1)'(value_reg);

    always_comb
    begin
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            row_sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            row_sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    // Stage two: square sum saturating at all ones.
    assign sqsum_wide      = {1'b0, square_sum_reg} + {1'b0, sq_reg};
    assign square_sum_next = sqsum_wide[SQ_BITS] ? {SQ_BITS{1'b1}} : sqsum_wide[SQ_BITS-1:0];

    // Magnitude of the row sum feeds the mean divider.
    assign sum_raw = $unsigned(row_sum_reg);
    assign sum_mag = row_sum_reg[SUM_BITS-1] ? (~sum_raw + 1'b1) : sum_raw;

    srvm_divider #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_div_mean (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (SQ_BITS'(sum_mag)),
        .divisor  (columns_reg),
        .quotient (q_mean)
    );

    srvm_divider #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_div_square (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (square_sum_reg),
        .divisor  (columns_reg),
        .quotient (q_square)
    );

    // Mean clamped before squaring, for rows with more entries than columns.
    assign mean_c   = (q_mean > SQ_BITS'(MEAN_CAP)) ? MEAN_CAP : q_mean[VALUE_BITS-1:0];
    assign msq_prod = mean_c * mean_c;

    // Variance floors at zero; the result drops the low fraction bits.
    assign var_next = (q_square > msq_reg) ? (q_square - msq_reg) : '0;
    assign row_var  = var_reg[FRACTION_BITS +: VAR_BITS];
    assign new_max  = (row_var > best_reg) ? row_var : best_reg;

    // A zero column count acts as one; larger counts clamp to the top.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            columns_next = COL_ONE;
        end
        else if (cfg_data[COLUMN_BITS])
        begin
            columns_next = COL_TOP;
        end
        else
        begin
            columns_next = cfg_data;
        end
    end

    // Control state, accumulators and the running maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= COL_ONE;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            row_sum_reg    <= '0;
            square_sum_reg <= '0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                columns_reg <= columns_next;
            end
            p1_valid_reg <= cmd.accept && in_has;
            p2_valid_reg <= p1_valid_reg;
            if (cmd.result_load)
            begin
                row_sum_reg    <= '0;
                square_sum_reg <= '0;
                best_reg       <= final_reg ? '0 : new_max;
            end
            else
            begin
                if (p1_valid_reg)
                begin
                    row_sum_reg <= row_sum_next;
                end
                if (p2_valid_reg)
                begin
                    square_sum_reg <= square_sum_next;
                end
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_reg   <= in_mag;
            value_reg <= in_entry;
            final_reg <= in_final;
        end
        if (p1_valid_reg)
        begin
            sq_reg <= SQ_BITS'(sq_prod);
        end
        if (cmd.square)
        begin
            msq_reg <= SQ_BITS'(msq_prod);
        end
        if (cmd.subtract)
        begin
            var_reg <= var_next;
        end
        if (cmd.result_load)
        begin
            out_row_reg   <= row_var;
            out_max_reg   <= new_max;
            out_final_reg <= final_reg;
        end
    end

    assign status.pipe_busy = p1_valid_reg || p2_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_row_variance = out_row_reg;
    assign out_max_variance = out_max_reg;
    assign out_final        = out_final_reg;

endmodule

// ----- src/srvm_checker.sv -----
`include "sparse_row_variance_max_defines.svh"

module srvm_checker
    import srvm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
    input logic                      s_axis_tlast,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    // A stalled result stays offered and unchanged.
    `SRVM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed or dropped")

    // The running maximum always covers the row it is reported with.
    `SRVM_ASSERT(a_max_covers_row, !m_axis_tvalid || (m_axis_tdata[OUT_TDATA_BITS-1:VAR_BITS] >= m_axis_tdata[VAR_BITS-1:0]), "maximum below row variance")

    // A request that closes a row holds off further input while the row is finished.
    `SRVM_ASSERT_NEXT(a_close_stalls, s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser[TUSER_MATRIX_END]), !s_axis_tready, "input taken during row close")

endmodule

bind sparse_row_variance_max srvm_checker u_srvm_checker (.*);
